### sv/sjfs_pkg.sv
// sjfs_pkg: shared widths, codes and control structs of the shortest-job-first run queue
// used by sjfs_ctrl, sjfs_dpath and shortest_job_first_scheduler_top; no dependencies
`timescale 1ns / 1ps

package sjfs_pkg;

   // fixed field widths
   localparam int ID_W    = 5;
   localparam int KEY_W   = 32;
   localparam int SLICE_W = 8;
   localparam int COUNT_W = 6;

   // slice length after reset
   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd100;

   // operation codes
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PICK    = 2'd2,
      OP_TICK    = 2'd3
   } sjfs_op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_DUP    = 2'd2,
      STAT_ABSENT = 2'd3
   } sjfs_status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK_WB,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK_DONE
   } sjfs_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic exec_enq;
      logic exec_deq;
      logic tick_wb;
      logic scan_clear;
      logic scan_issue;
      logic pick_done;
   } sjfs_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      sjfs_op_type op;
      logic        scan_last;
   } sjfs_stat_type;

endpackage

### sv/sjfs_ctrl.sv
// sjfs_ctrl: sequencing state machine of the run queue
// depends on sjfs_pkg for the state enum and the command and status structs
`timescale 1ns / 1ps

module sjfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sjfs_pkg::sjfs_stat_type stat,
   output sjfs_pkg::sjfs_cmd_type  cmd
);

   sjfs_pkg::sjfs_state_type state_ff;
   sjfs_pkg::sjfs_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sjfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != sjfs_pkg::ST_IDLE);
      case (state_ff)
         sjfs_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = sjfs_pkg::ST_DISPATCH;
            end
         end
         sjfs_pkg::ST_DISPATCH: begin
            case (stat.op)
               sjfs_pkg::OP_ENQUEUE: begin
                  cmd.exec_enq = 1'b1;
                  state_in     = sjfs_pkg::ST_IDLE;
               end
               sjfs_pkg::OP_DEQUEUE: begin
                  cmd.exec_deq = 1'b1;
                  state_in     = sjfs_pkg::ST_IDLE;
               end
               sjfs_pkg::OP_PICK: begin
                  cmd.scan_clear = 1'b1;
                  state_in       = sjfs_pkg::ST_SCAN;
               end
               default: begin
                  // tick: slice read is in flight this cycle
                  state_in = sjfs_pkg::ST_TICK_WB;
               end
            endcase
         end
         sjfs_pkg::ST_TICK_WB: begin
            cmd.tick_wb = 1'b1;
            state_in    = sjfs_pkg::ST_IDLE;
         end
         sjfs_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = sjfs_pkg::ST_DRAIN;
            end
         end
         sjfs_pkg::ST_DRAIN: begin
            // last compare happens in the datapath this cycle
            state_in = sjfs_pkg::ST_PICK_DONE;
         end
         sjfs_pkg::ST_PICK_DONE: begin
            cmd.pick_done = 1'b1;
            state_in      = sjfs_pkg::ST_IDLE;
         end
         default: begin
            state_in = sjfs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/sjfs_dpath.sv
// sjfs_dpath: slot tables, key and slice memories, pick comparator and result register
// depends on sjfs_pkg; driven by sjfs_ctrl through sjfs_cmd_type
`timescale 1ns / 1ps

module sjfs_dpath #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sjfs_pkg::sjfs_cmd_type         cmd,
   output sjfs_pkg::sjfs_stat_type        stat,
   input  logic [1:0]                    req_op,
   input  logic [sjfs_pkg::ID_W-1:0]     req_slot_id,
   input  logic [sjfs_pkg::KEY_W-1:0]    req_expected_time,
   input  logic                          csr_write_en,
   input  logic [sjfs_pkg::SLICE_W-1:0]  csr_write_data,
   output logic                          rsp_valid,
   output logic                          rsp_picked_valid,
   output logic [sjfs_pkg::ID_W-1:0]     rsp_picked_id,
   output logic                          rsp_resched_needed,
   output logic [sjfs_pkg::COUNT_W-1:0]  rsp_queued_count,
   output logic [1:0]                    rsp_status
);

   localparam int ID_W    = sjfs_pkg::ID_W;
   localparam int KEY_W   = sjfs_pkg::KEY_W;
   localparam int SLICE_W = sjfs_pkg::SLICE_W;
   localparam int COUNT_W = sjfs_pkg::COUNT_W;
   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);

   // captured item
   sjfs_pkg::sjfs_op_type op_ff;
   logic [ID_W-1:0]       id_ff;
   logic [KEY_W-1:0]      key_ff;

   // configuration and slot state
   logic [SLICE_W-1:0]    slice_len_ff;
   logic [SLOT_COUNT-1:0] queued_ff;
   logic [SLOT_COUNT-1:0] queued_in;
   logic [SLOT_COUNT-1:0] slice_vld_ff;
   logic [SLOT_COUNT-1:0] slice_vld_in;
   logic [CNT_W-1:0]      size_ff;
   logic [CNT_W-1:0]      size_in;

   // memories
   logic [KEY_W-1:0]      key_mem [SLOT_COUNT];
   logic [SLICE_W-1:0]    slice_mem [SLOT_COUNT];
   logic [KEY_W-1:0]      key_rd_ff;
   logic [SLICE_W-1:0]    slice_rd_ff;

   // scan pipeline
   logic [IDX_W-1:0]      scan_cnt_ff;
   logic                  cmp_vld_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic                  best_vld_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [KEY_W-1:0]      best_key_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  pv_ff, pv_in;
   logic [ID_W-1:0]       pid_ff, pid_in;
   logic                  rs_ff, rs_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   sjfs_pkg::sjfs_status_type st_ff, st_in;

   // combinational helpers
   logic [IDX_W-1:0]      slot_idx;
   logic [IDX_W-1:0]      key_addr;
   logic                  in_table;
   logic                  full;
   logic                  better;
   logic [SLICE_W-1:0]    slice_cur;
   logic [SLICE_W-1:0]    slice_new;
   logic                  slice_we;
   logic [SLICE_W-1:0]    slice_wdata;

   assign slot_idx = IDX_W'(id_ff);
   assign in_table = (32'(id_ff) < SLOT_COUNT);
   assign full     = (size_ff >= CNT_W'(SLOT_COUNT));
   assign key_addr = cmd.scan_issue ? scan_cnt_ff : slot_idx;

   // status to the controller: captured op and last scan address
   assign stat = {op_ff, (scan_cnt_ff == IDX_W'(SLOT_COUNT - 1))};

   // tick arithmetic, unwritten slices read as zero
   assign slice_cur = slice_vld_ff[slot_idx] ? slice_rd_ff : '0;
   assign slice_new = (slice_cur != '0) ? slice_cur - SLICE_W'(1) : '0;

   // pick compare, unsigned keys, first found wins ties
   assign better = cmp_vld_ff && queued_ff[cmp_idx_ff] &&
                   (!best_vld_ff || (key_rd_ff < best_key_ff));

   // capture of the item and the slice length register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= sjfs_pkg::sjfs_op_type'(req_op);
         id_ff  <= req_slot_id;
         key_ff <= req_expected_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_len_ff <= sjfs_pkg::SLICE_RESET;
      end else if (csr_write_en) begin
         slice_len_ff <= csr_write_data;
      end
   end

   // operation logic and result fields
   always_comb begin
      queued_in    = queued_ff;
      slice_vld_in = slice_vld_ff;
      size_in      = size_ff;
      slice_we     = 1'b0;
      slice_wdata  = slice_len_ff;
      rsp_valid_in = 1'b0;
      pv_in        = 1'b0;
      pid_in       = '0;
      rs_in        = 1'b0;
      st_in        = sjfs_pkg::STAT_OK;
      if (cmd.exec_enq) begin
         rsp_valid_in = 1'b1;
         if (!in_table) begin
            st_in = sjfs_pkg::STAT_FULL;
         end else if (queued_ff[slot_idx]) begin
            st_in = sjfs_pkg::STAT_DUP;
         end else if (full) begin
            st_in = sjfs_pkg::STAT_FULL;
         end else begin
            queued_in[slot_idx]    = 1'b1;
            slice_vld_in[slot_idx] = 1'b1;
            slice_we               = 1'b1;
            size_in                = size_ff + CNT_W'(1);
         end
      end
      if (cmd.exec_deq) begin
         rsp_valid_in = 1'b1;
         if (!in_table || !queued_ff[slot_idx]) begin
            st_in = sjfs_pkg::STAT_ABSENT;
         end else begin
            queued_in[slot_idx] = 1'b0;
            size_in             = size_ff - CNT_W'(1);
         end
      end
      if (cmd.tick_wb) begin
         rsp_valid_in = 1'b1;
         if (in_table) begin
            rs_in       = (slice_new == '0);
            slice_we    = slice_vld_ff[slot_idx];
            slice_wdata = slice_new;
         end
      end
      if (cmd.pick_done) begin
         rsp_valid_in = 1'b1;
         pv_in        = best_vld_ff;
         pid_in       = best_vld_ff ? ID_W'(best_idx_ff) : '0;
      end
      cnt_in = COUNT_W'(size_in);
   end

   // slot state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff    <= '0;
         slice_vld_ff <= '0;
         size_ff      <= '0;
      end else begin
         queued_ff    <= queued_in;
         slice_vld_ff <= slice_vld_in;
         size_ff      <= size_in;
      end
   end

   // key memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec_enq && slice_we) begin
         key_mem[slot_idx] <= key_ff;
      end
      key_rd_ff <= key_mem[key_addr];
   end

   // slice memory
   always_ff @(posedge clock) begin
      if (slice_we) begin
         slice_mem[slot_idx] <= slice_wdata;
      end
      slice_rd_ff <= slice_mem[slot_idx];
   end

   // scan counter and compare pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         cmp_vld_ff  <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_issue;
         if (cmd.scan_clear) begin
            scan_cnt_ff <= '0;
            best_vld_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
            end
            if (better) begin
               best_vld_ff <= 1'b1;
            end
         end
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_cnt_ff;
      if (better) begin
         best_idx_ff <= cmp_idx_ff;
         best_key_ff <= key_rd_ff;
      end
   end

   // result strobe and fields
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         pv_ff  <= pv_in;
         pid_ff <= pid_in;
         rs_ff  <= rs_in;
         cnt_ff <= cnt_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_picked_valid   = pv_ff;
   assign rsp_picked_id      = pid_ff;
   assign rsp_resched_needed = rs_ff;
   assign rsp_queued_count   = cnt_ff;
   assign rsp_status         = st_ff;

endmodule

### sv/shortest_job_first_scheduler_top.sv
// shortest-job-first run queue: enqueue and dequeue pass DISPATCH, tick DISPATCH and TICK_WB,
// pick DISPATCH, SCAN (one key memory read and compare per slot), DRAIN and PICK_DONE,
// then the result register strobes; a new item is taken in the strobe cycle
// results cannot be stalled; synchronous reset empties the queue, sets the slice length to 100
// and marks all slices as zero through per-slot valid bits; keys stay undefined until written
// depends on sjfs_pkg, sjfs_ctrl and sjfs_dpath
`timescale 1ns / 1ps

module shortest_job_first_scheduler_top #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [sjfs_pkg::ID_W-1:0]     req_slot_id,
   input  logic [sjfs_pkg::KEY_W-1:0]    req_expected_time,
   input  logic                          csr_write_en,
   input  logic [sjfs_pkg::SLICE_W-1:0]  csr_write_data,
   output logic                          rsp_valid,
   output logic                          rsp_picked_valid,
   output logic [sjfs_pkg::ID_W-1:0]     rsp_picked_id,
   output logic                          rsp_resched_needed,
   output logic [sjfs_pkg::COUNT_W-1:0]  rsp_queued_count,
   output logic [1:0]                    rsp_status
);

   sjfs_pkg::sjfs_cmd_type  cmd;
   sjfs_pkg::sjfs_stat_type stat;

   // sequencer
   sjfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // tables, memories and result register
   sjfs_dpath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_op),
      .req_slot_id        (req_slot_id),
      .req_expected_time  (req_expected_time),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_picked_valid   (rsp_picked_valid),
      .rsp_picked_id      (rsp_picked_id),
      .rsp_resched_needed (rsp_resched_needed),
      .rsp_queued_count   (rsp_queued_count),
      .rsp_status         (rsp_status)
   );

   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // a result is only strobed once the sequencer is back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   // every item passes DISPATCH before its strobe, so strobes never sit back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // a successful pick carries ok status and no reschedule flag
   a_pick_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_picked_valid) |->
         (rsp_status == sjfs_pkg::STAT_OK) && !rsp_resched_needed)
      else $error("pick result mixed with other fields");

endmodule

### sim/sjfs_run_queue_checker.sv
// sjfs_run_queue_checker: watches the item, result and csr ports of the run queue,
// predicts each result from its own copy of the slot table and compares field by field
// depends on sjfs_pkg; instantiated beside the block by tb_top
`timescale 1ns / 1ps

module sjfs_run_queue_checker #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [sjfs_pkg::ID_W-1:0]     req_slot_id,
   input  logic [sjfs_pkg::KEY_W-1:0]    req_expected_time,
   input  logic                          csr_write_en,
   input  logic [sjfs_pkg::SLICE_W-1:0]  csr_write_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_picked_valid,
   input  logic [sjfs_pkg::ID_W-1:0]     rsp_picked_id,
   input  logic                          rsp_resched_needed,
   input  logic [sjfs_pkg::COUNT_W-1:0]  rsp_queued_count,
   input  logic [1:0]                    rsp_status,
   output int                            fail_count,
   output int                            outstanding
);

   // one expected result item
   typedef struct {
      logic                              picked_valid;
      logic [sjfs_pkg::ID_W-1:0]         picked_id;
      logic                              resched;
      logic [sjfs_pkg::COUNT_W-1:0]      count;
      sjfs_pkg::sjfs_status_type         status;
   } sched_outcome_type;

   // shadow slot table
   logic [SLOT_COUNT-1:0]           on_queue;
   logic [sjfs_pkg::KEY_W-1:0]      run_key    [SLOT_COUNT];
   logic [sjfs_pkg::SLICE_W-1:0]    slice_left [SLOT_COUNT];
   int unsigned                     queue_len;
   logic [sjfs_pkg::SLICE_W-1:0]    slice_len;

   sched_outcome_type pending_outcomes [$];
   sched_outcome_type head;
   int                mismatches = 0;

   // apply one item to the shadow table and return the result it should give
   function automatic sched_outcome_type apply_sched_op(sjfs_pkg::sjfs_op_type op,
                                                        logic [sjfs_pkg::ID_W-1:0] id,
                                                        logic [sjfs_pkg::KEY_W-1:0] key);
      sched_outcome_type          o;
      logic                       in_table;
      logic [sjfs_pkg::KEY_W-1:0] best;
      o.picked_valid = 1'b0;
      o.picked_id    = '0;
      o.resched      = 1'b0;
      o.status       = sjfs_pkg::STAT_OK;
      best           = '0;
      in_table       = (int'(id) < SLOT_COUNT);
      case (op)
         sjfs_pkg::OP_ENQUEUE: begin
            // duplicate test comes before the full-table test
            if (!in_table) begin
               o.status = sjfs_pkg::STAT_FULL;
            end else if (on_queue[id]) begin
               o.status = sjfs_pkg::STAT_DUP;
            end else if (queue_len >= SLOT_COUNT) begin
               o.status = sjfs_pkg::STAT_FULL;
            end else begin
               on_queue[id]   = 1'b1;
               run_key[id]    = key;
               slice_left[id] = slice_len;
               queue_len++;
            end
         end
         sjfs_pkg::OP_DEQUEUE: begin
            // key and slice stay as they are
            if (!in_table || !on_queue[id]) begin
               o.status = sjfs_pkg::STAT_ABSENT;
            end else begin
               on_queue[id] = 1'b0;
               queue_len--;
            end
         end
         sjfs_pkg::OP_PICK: begin
            // unsigned compare, strict less keeps the lowest slot on ties
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (on_queue[i] && (!o.picked_valid || run_key[i] < best)) begin
                  o.picked_valid = 1'b1;
                  o.picked_id    = sjfs_pkg::ID_W'(i);
                  best           = run_key[i];
               end
            end
         end
         default: begin
            // tick counts down whether or not the slot is queued
            if (in_table) begin
               if (slice_left[id] != '0) slice_left[id]--;
               if (slice_left[id] == '0) o.resched = 1'b1;
            end
         end
      endcase
      o.count = sjfs_pkg::COUNT_W'(queue_len);
      return o;
   endfunction

   task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
      end
   endtask

   // compare results, track csr writes, predict accepted items
   always @(posedge clock) begin
      if (reset) begin
         on_queue  = '0;
         queue_len = 0;
         slice_len = sjfs_pkg::SLICE_RESET;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            run_key[i]    = '0;
            slice_left[i] = '0;
         end
         pending_outcomes.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: result item, expected none, actual status %0d", $time,
                        rsp_status);
            end else begin
               head = pending_outcomes.pop_front();
               check_field("picked_valid", 32'(head.picked_valid), 32'(rsp_picked_valid));
               check_field("picked_id", 32'(head.picked_id), 32'(rsp_picked_id));
               check_field("resched_needed", 32'(head.resched), 32'(rsp_resched_needed));
               check_field("queued_count", 32'(head.count), 32'(rsp_queued_count));
               check_field("status", 32'(head.status), 32'(rsp_status));
            end
         end
         if (csr_write_en) slice_len = csr_write_data;
         if (start && !busy)
            pending_outcomes.push_back(apply_sched_op(sjfs_pkg::sjfs_op_type'(req_op),
                                                      req_slot_id, req_expected_time));
      end
      fail_count  <= mismatches;
      outstanding <= pending_outcomes.size();
   end

endmodule

### sim/tb_top.sv
// tb_top: stimulus for the shortest-job-first run queue: directed items, then phases of
// random items under varied slice lengths and sender gaps; verdict from the checker count
// depends on sjfs_pkg, shortest_job_first_scheduler_top and sjfs_run_queue_checker
`timescale 1ns / 1ps

module tb_top;

   localparam int SLOT_COUNT = 32;
   localparam int IDLE_LIMIT = 2000;

   logic                           clock             = 1'b0;
   logic                           reset             = 1'b1;
   logic                           start             = 1'b0;
   logic                           busy;
   logic [1:0]                     req_op            = sjfs_pkg::OP_PICK;
   logic [sjfs_pkg::ID_W-1:0]      req_slot_id       = '0;
   logic [sjfs_pkg::KEY_W-1:0]     req_expected_time = '0;
   logic                           csr_write_en      = 1'b0;
   logic [sjfs_pkg::SLICE_W-1:0]   csr_write_data    = '0;
   logic                           rsp_valid;
   logic                           rsp_picked_valid;
   logic [sjfs_pkg::ID_W-1:0]      rsp_picked_id;
   logic                           rsp_resched_needed;
   logic [sjfs_pkg::COUNT_W-1:0]   rsp_queued_count;
   logic [1:0]                     rsp_status;

   int fail_count;
   int outstanding;
   int quiet_cycles = 0;

   // knobs of the current phase
   int idle_pct  = 0;
   int enq_w     = 25;
   int deq_w     = 25;
   int pick_w    = 25;
   int hot_slots = 4;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   shortest_job_first_scheduler_top #(
      .SLOT_COUNT(SLOT_COUNT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_slot_id        (req_slot_id),
      .req_expected_time  (req_expected_time),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_picked_valid   (rsp_picked_valid),
      .rsp_picked_id      (rsp_picked_id),
      .rsp_resched_needed (rsp_resched_needed),
      .rsp_queued_count   (rsp_queued_count),
      .rsp_status         (rsp_status)
   );

   sjfs_run_queue_checker #(
      .SLOT_COUNT(SLOT_COUNT)
   ) i_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_slot_id        (req_slot_id),
      .req_expected_time  (req_expected_time),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_picked_valid   (rsp_picked_valid),
      .rsp_picked_id      (rsp_picked_id),
      .rsp_resched_needed (rsp_resched_needed),
      .rsp_queued_count   (rsp_queued_count),
      .rsp_status         (rsp_status),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // watchdog: cycles with neither an item nor a result accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one item, with a random sender gap first, and wait until it is taken
   task automatic issue_item(sjfs_pkg::sjfs_op_type op, logic [sjfs_pkg::ID_W-1:0] id,
                             logic [sjfs_pkg::KEY_W-1:0] key);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_op            <= op;
      req_slot_id       <= id;
      req_expected_time <= key;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // slice length write once the queue block has gone quiet
   task automatic write_slice(logic [sjfs_pkg::SLICE_W-1:0] len);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // keys lean to the extremes and to small values so that ties are common
   function automatic logic [sjfs_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 12) return '0;
      if (r < 24) return '1;
      if (r < 50) return sjfs_pkg::KEY_W'($urandom_range(7));
      if (r < 60) return 32'h8000_0000 - 32'd4 + sjfs_pkg::KEY_W'($urandom_range(7));
      return sjfs_pkg::KEY_W'($urandom);
   endfunction

   task automatic random_item();
      int                        r;
      sjfs_pkg::sjfs_op_type     op;
      logic [sjfs_pkg::ID_W-1:0] id;
      r = $urandom_range(99);
      if (r < enq_w)                       op = sjfs_pkg::OP_ENQUEUE;
      else if (r < enq_w + deq_w)          op = sjfs_pkg::OP_DEQUEUE;
      else if (r < enq_w + deq_w + pick_w) op = sjfs_pkg::OP_PICK;
      else                                 op = sjfs_pkg::OP_TICK;
      // a few hot slots so that ticks run slices down and duplicates turn up
      if ($urandom_range(99) < 35) id = sjfs_pkg::ID_W'($urandom_range(hot_slots - 1));
      else                         id = sjfs_pkg::ID_W'($urandom_range(SLOT_COUNT - 1));
      issue_item(op, id, pick_key());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset slice length
      issue_item(sjfs_pkg::OP_PICK, 5'd0, 32'd0);
      issue_item(sjfs_pkg::OP_DEQUEUE, 5'd5, 32'd0);
      issue_item(sjfs_pkg::OP_TICK, 5'd3, 32'd0);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd0, 32'hFFFF_FFFF);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd31, 32'd0);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd0, 32'd1);
      issue_item(sjfs_pkg::OP_PICK, 5'd0, 32'd0);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd7, 32'd0);
      issue_item(sjfs_pkg::OP_PICK, 5'd0, 32'd0);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd16, 32'h8000_0000);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd8, 32'h7FFF_FFFF);
      issue_item(sjfs_pkg::OP_DEQUEUE, 5'd31, 32'd0);
      issue_item(sjfs_pkg::OP_DEQUEUE, 5'd7, 32'd0);
      issue_item(sjfs_pkg::OP_PICK, 5'd0, 32'd0);
      issue_item(sjfs_pkg::OP_TICK, 5'd8, 32'd0);
      issue_item(sjfs_pkg::OP_DEQUEUE, 5'd8, 32'd0);
      issue_item(sjfs_pkg::OP_TICK, 5'd8, 32'd0);
      // slice length 1: first tick flags reschedule, next one stays at zero
      write_slice(8'd1);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd21, 32'h5A5A_5A5A);
      issue_item(sjfs_pkg::OP_TICK, 5'd21, 32'd0);
      issue_item(sjfs_pkg::OP_TICK, 5'd21, 32'd0);
      // zero slice length
      write_slice(8'd0);
      issue_item(sjfs_pkg::OP_ENQUEUE, 5'd10, 32'hA5A5_A5A5);
      issue_item(sjfs_pkg::OP_TICK, 5'd10, 32'd0);
      issue_item(sjfs_pkg::OP_DEQUEUE, 5'd10, 32'd0);
      issue_item(sjfs_pkg::OP_PICK, 5'd0, 32'd0);

      // random phases: fill, churn, drain and tick-heavy mixes
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  enq_w = 60; deq_w = 10; pick_w = 15; hot_slots = 4;
               write_slice(8'd255); end
            1: begin idle_pct = 81; enq_w = 30; deq_w = 30; pick_w = 20; hot_slots = 4;
               write_slice(8'd1); end
            2: begin idle_pct = 30; enq_w = 10; deq_w = 60; pick_w = 15; hot_slots = 4;
               write_slice(8'd0); end
            3: begin idle_pct = 0;  enq_w = 25; deq_w = 15; pick_w = 10; hot_slots = 2;
               write_slice(sjfs_pkg::SLICE_W'($urandom_range(2, 12))); end
            4: begin idle_pct = 81; enq_w = 55; deq_w = 15; pick_w = 15; hot_slots = 4;
               write_slice(8'd2); end
            5: begin idle_pct = 0;  enq_w = 35; deq_w = 30; pick_w = 20; hot_slots = 4;
               write_slice(sjfs_pkg::SLICE_W'($urandom_range(1, 254))); end
            default: begin idle_pct = 30; enq_w = 30; deq_w = 25; pick_w = 25; hot_slots = 4;
               write_slice(8'd255); end
         endcase
         repeat (200) random_item();
      end

      // drain and allow a full pick scan for stray results
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SLOT_COUNT + 8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
sv/sjfs_pkg.sv
sv/sjfs_ctrl.sv
sv/sjfs_dpath.sv
sv/shortest_job_first_scheduler_top.sv
sim/sjfs_run_queue_checker.sv
sim/tb_top.sv
